### hw/rtl/rtc_pkg.sv
// rtc_pkg: shared types, register indexes and the arithmetic microprogram
// for the ray/triangle closest-hit block; no dependencies
package rtc_pkg;

   localparam int ACC_W = 104;   // holds every exact product sum of the test
   localparam int NAR_W = 33;    // vertex differences and the direction
   localparam int WID_W = 68;    // cross product terms
   localparam int OPB_W = 35;    // second multiplier operand
   localparam int SPLIT = 33;    // where a cross product term is cut in two
   localparam int MAC_STEPS = 36;
   localparam int DIV_STEPS = 31;

   // register indexes of the csr port
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X    = 3'd3;
   localparam logic [2:0] REG_DIR_Y    = 3'd4;
   localparam logic [2:0] REG_DIR_Z    = 3'd5;
   localparam logic [2:0] REG_LIMIT    = 3'd6;

   // operand selects: narrow operands 0..11, cross product terms 12..17
   localparam logic [4:0] OP_D0  = 5'd0;
   localparam logic [4:0] OP_D1  = 5'd1;
   localparam logic [4:0] OP_D2  = 5'd2;
   localparam logic [4:0] OP_S0  = 5'd3;
   localparam logic [4:0] OP_S1  = 5'd4;
   localparam logic [4:0] OP_S2  = 5'd5;
   localparam logic [4:0] OP_E10 = 5'd6;
   localparam logic [4:0] OP_E11 = 5'd7;
   localparam logic [4:0] OP_E12 = 5'd8;
   localparam logic [4:0] OP_E20 = 5'd9;
   localparam logic [4:0] OP_E21 = 5'd10;
   localparam logic [4:0] OP_E22 = 5'd11;
   localparam logic [4:0] OP_H0  = 5'd12;
   localparam logic [4:0] OP_H1  = 5'd13;
   localparam logic [4:0] OP_H2  = 5'd14;
   localparam logic [4:0] OP_Q0  = 5'd15;
   localparam logic [4:0] OP_Q1  = 5'd16;
   localparam logic [4:0] OP_Q2  = 5'd17;
   localparam logic [4:0] OP_WIDE = 5'd12;

   typedef enum logic [3:0] {
      DST_NONE = 4'd0,
      DST_H0   = 4'd1,
      DST_H1   = 4'd2,
      DST_H2   = 4'd3,
      DST_Q0   = 4'd4,
      DST_Q1   = 4'd5,
      DST_Q2   = 4'd6,
      DST_DET  = 4'd7,
      DST_U    = 4'd8,
      DST_V    = 4'd9,
      DST_T    = 4'd10
   } dest_type;

   typedef struct packed {
      logic [4:0] a_sel;
      logic [4:0] b_sel;
      logic       b_hi;
      logic       sub;
      logic       clr;
      dest_type   dest;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    mac;
      uop_type uop;
      logic    norm;
      logic    check;
      logic    div_step;
      logic    commit;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   typedef struct packed {
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] c_x;
      logic signed [31:0] c_y;
      logic signed [31:0] c_z;
      logic [15:0]        tri_index;
      logic               final_candidate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [30:0]        distance_limit;
   } ray_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] hit_distance;
      logic [15:0] hit_index;
   } rsp_type;

   function automatic uop_type mk(input logic [4:0] a, input logic [4:0] b,
                                  input logic hi, input logic sub, input logic clr,
                                  input dest_type dst);
      uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.b_hi  = hi;
      u.sub   = sub;
      u.clr   = clr;
      u.dest  = dst;
      return u;
   endfunction

   // h = d x e2, q = s x e1, then det = e1.h, U = s.h, V = d.q, T = e2.q
   function automatic uop_type rtc_uop(input logic [5:0] step);
      uop_type u;
      u = mk(OP_D0, OP_D0, 1'b0, 1'b0, 1'b0, DST_NONE);
      unique case (step)
         6'd0:  u = mk(OP_D1,  OP_E22, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd1:  u = mk(OP_D2,  OP_E21, 1'b0, 1'b1, 1'b0, DST_H0);
         6'd2:  u = mk(OP_D2,  OP_E20, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd3:  u = mk(OP_D0,  OP_E22, 1'b0, 1'b1, 1'b0, DST_H1);
         6'd4:  u = mk(OP_D0,  OP_E21, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd5:  u = mk(OP_D1,  OP_E20, 1'b0, 1'b1, 1'b0, DST_H2);
         6'd6:  u = mk(OP_S1,  OP_E12, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd7:  u = mk(OP_S2,  OP_E11, 1'b0, 1'b1, 1'b0, DST_Q0);
         6'd8:  u = mk(OP_S2,  OP_E10, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd9:  u = mk(OP_S0,  OP_E12, 1'b0, 1'b1, 1'b0, DST_Q1);
         6'd10: u = mk(OP_S0,  OP_E11, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd11: u = mk(OP_S1,  OP_E10, 1'b0, 1'b1, 1'b0, DST_Q2);
         6'd12: u = mk(OP_E10, OP_H0,  1'b0, 1'b0, 1'b1, DST_NONE);
         6'd13: u = mk(OP_E10, OP_H0,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd14: u = mk(OP_E11, OP_H1,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd15: u = mk(OP_E11, OP_H1,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd16: u = mk(OP_E12, OP_H2,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd17: u = mk(OP_E12, OP_H2,  1'b1, 1'b0, 1'b0, DST_DET);
         6'd18: u = mk(OP_S0,  OP_H0,  1'b0, 1'b0, 1'b1, DST_NONE);
         6'd19: u = mk(OP_S0,  OP_H0,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd20: u = mk(OP_S1,  OP_H1,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd21: u = mk(OP_S1,  OP_H1,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd22: u = mk(OP_S2,  OP_H2,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd23: u = mk(OP_S2,  OP_H2,  1'b1, 1'b0, 1'b0, DST_U);
         6'd24: u = mk(OP_D0,  OP_Q0,  1'b0, 1'b0, 1'b1, DST_NONE);
         6'd25: u = mk(OP_D0,  OP_Q0,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd26: u = mk(OP_D1,  OP_Q1,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd27: u = mk(OP_D1,  OP_Q1,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd28: u = mk(OP_D2,  OP_Q2,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd29: u = mk(OP_D2,  OP_Q2,  1'b1, 1'b0, 1'b0, DST_V);
         6'd30: u = mk(OP_E20, OP_Q0,  1'b0, 1'b0, 1'b1, DST_NONE);
         6'd31: u = mk(OP_E20, OP_Q0,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd32: u = mk(OP_E21, OP_Q1,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd33: u = mk(OP_E21, OP_Q1,  1'b1, 1'b0, 1'b0, DST_NONE);
         6'd34: u = mk(OP_E22, OP_Q2,  1'b0, 1'b0, 1'b0, DST_NONE);
         6'd35: u = mk(OP_E22, OP_Q2,  1'b1, 1'b0, 1'b0, DST_T);
         default: u = mk(OP_D0, OP_D0, 1'b0, 1'b0, 1'b0, DST_NONE);
      endcase
      return u;
   endfunction

endpackage

### hw/rtl/rtc_if.sv
// rtc_if: valid/ready channel interfaces of the closest-hit block
// (triangle requests, results, csr writes); no dependencies
interface rtc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] c_x;
   logic signed [31:0] c_y;
   logic signed [31:0] c_z;
   logic [15:0]        tri_index;
   logic               final_candidate;
   modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  tri_index, final_candidate, input ready);
   modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                tri_index, final_candidate, output ready);
endinterface

interface rtc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [30:0] hit_distance;
   logic [15:0] hit_index;
   modport source(output valid, hit, hit_distance, hit_index, input ready);
   modport sink(input valid, hit, hit_distance, hit_index, output ready);
endinterface

interface rtc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] data;
   modport source(output valid, addr, data, input ready);
   modport sink(input valid, addr, data, output ready);
endinterface

### hw/rtl/rtc_ctrl.sv
// rtc_ctrl: sequencer of the closest-hit block, steps the datapath through
// load, products, sign fix, checks, division and commit; uses rtc_pkg
module rtc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rtc_pkg::status_type status,
   output rtc_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MAC    = 6'b000010,
      S_NORM   = 6'b000100,
      S_CHECK  = 6'b001000,
      S_DIV    = 6'b010000,
      S_COMMIT = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       blocked;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // a final result cannot overwrite one not yet taken
   assign blocked = status.last && rsp_valid_ff && !rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.uop      = rtc_pkg::rtc_uop(step_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mac = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(rtc_pkg::MAC_STEPS - 1)) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            cmd.norm = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            step_in   = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 6'd1;
            if (step_ff == 6'(rtc_pkg::DIV_STEPS - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (!blocked) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
               if (status.last) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/rtc_datapath.sv
// rtc_datapath: shared multiply-accumulate, sign fix, range checks,
// restoring divider and closest-hit state; uses rtc_pkg
module rtc_datapath #(
   parameter int FRAC_BITS  = 16,
   parameter int INDEX_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rtc_pkg::cmd_type    cmd,
   input  rtc_pkg::req_type    req,
   input  rtc_pkg::ray_type    ray,
   output rtc_pkg::status_type status,
   output rtc_pkg::rsp_type    rsp
);

   localparam int AW = rtc_pkg::ACC_W;
   localparam int NW = rtc_pkg::NAR_W;
   localparam int WW = rtc_pkg::WID_W;
   localparam int BW = rtc_pkg::OPB_W;
   localparam int DW = AW + 32;
   localparam logic [15:0] IDX_MASK =
      (INDEX_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << INDEX_BITS) - 32'd1);

   logic signed [NW-1:0] s_ff [3];
   logic signed [NW-1:0] e1_ff [3];
   logic signed [NW-1:0] e2_ff [3];
   logic signed [WW-1:0] wide_ff [6];
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] det_ff, u_ff, v_ff, t_ff;
   logic [15:0]          idx_ff;
   logic                 last_ff;
   logic                 ok_ff;
   logic [DW-1:0]        rem_ff, dv_ff;
   logic [30:0]          quot_ff;
   logic                 have_ff;
   logic [30:0]          best_dist_ff;
   logic [15:0]          best_idx_ff;
   rtc_pkg::rsp_type     rsp_ff;

   logic signed [NW-1:0] nar [16];
   logic signed [WW-1:0] wide_rd [8];
   logic signed [NW-1:0] op_a;
   logic signed [BW-1:0] op_b;
   logic signed [WW-1:0] w_sel;
   logic [4:0]           w_idx;
   logic signed [NW+BW-1:0] prod;
   logic signed [AW-1:0] term, base;
   logic                 neg;
   logic signed [AW:0]   uv_sum;
   logic                 range_ok;
   logic [DW-1:0]        num0, dv0;
   logic                 overflow;
   logic [DW-1:0]        rem_sub;
   logic                 take;
   logic [30:0]          bound;
   logic                 hit_now;
   logic                 have_new;
   logic [30:0]          dist_new;
   logic [15:0]          idx_new;

   assign status.last = last_ff;
   assign rsp         = rsp_ff;

   // sign of the determinant decides the sign fix
   assign neg = det_ff[AW-1];

   // operand fields
   always_comb begin
      nar[0]  = {ray.dir_x[31], ray.dir_x};
      nar[1]  = {ray.dir_y[31], ray.dir_y};
      nar[2]  = {ray.dir_z[31], ray.dir_z};
      nar[3]  = s_ff[0];
      nar[4]  = s_ff[1];
      nar[5]  = s_ff[2];
      nar[6]  = e1_ff[0];
      nar[7]  = e1_ff[1];
      nar[8]  = e1_ff[2];
      nar[9]  = e2_ff[0];
      nar[10] = e2_ff[1];
      nar[11] = e2_ff[2];
      nar[12] = '0;
      nar[13] = '0;
      nar[14] = '0;
      nar[15] = '0;
      for (int i = 0; i < 6; i++) begin
         wide_rd[i] = wide_ff[i];
      end
      wide_rd[6] = '0;
      wide_rd[7] = '0;
   end

   // one multiply-accumulate a cycle; wide terms go in as two halves
   always_comb begin
      op_a  = nar[cmd.uop.a_sel[3:0]];
      w_idx = cmd.uop.b_sel - rtc_pkg::OP_WIDE;
      w_sel = wide_rd[w_idx[2:0]];
      if (cmd.uop.b_sel < rtc_pkg::OP_WIDE) begin
         op_b = BW'(nar[cmd.uop.b_sel[3:0]]);
      end else if (cmd.uop.b_hi) begin
         op_b = w_sel[WW-1:rtc_pkg::SPLIT];
      end else begin
         op_b = {2'b00, w_sel[rtc_pkg::SPLIT-1:0]};
      end
      prod = op_a * op_b;
      term = cmd.uop.b_hi ? (AW'(prod) <<< rtc_pkg::SPLIT) : AW'(prod);
      base = cmd.uop.clr ? '0 : acc_ff;
      acc_in = cmd.uop.sub ? (base - term) : (base + term);
   end

   // range checks on the sign-fixed values
   always_comb begin
      uv_sum   = (AW+1)'(u_ff) + (AW+1)'(v_ff);
      range_ok = (det_ff != '0) && !u_ff[AW-1] && (u_ff <= det_ff) && !v_ff[AW-1]
                 && (uv_sum <= (AW+1)'(det_ff)) && !t_ff[AW-1];
      num0     = DW'(t_ff) << FRAC_BITS;
      dv0      = DW'(det_ff) << 30;
      overflow = num0 >= (dv0 << 1);
   end

   // restoring division step
   always_comb begin
      take    = rem_ff >= dv_ff;
      rem_sub = rem_ff - dv_ff;
   end

   // closest-hit update
   always_comb begin
      bound    = have_ff ? best_dist_ff : ray.distance_limit;
      hit_now  = ok_ff && (quot_ff < bound);
      have_new = have_ff || hit_now;
      dist_new = hit_now ? quot_ff : best_dist_ff;
      idx_new  = hit_now ? (idx_ff & IDX_MASK) : best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff[0]  <= NW'(ray.origin_x) - NW'(req.a_x);
         s_ff[1]  <= NW'(ray.origin_y) - NW'(req.a_y);
         s_ff[2]  <= NW'(ray.origin_z) - NW'(req.a_z);
         e1_ff[0] <= NW'(req.b_x) - NW'(req.a_x);
         e1_ff[1] <= NW'(req.b_y) - NW'(req.a_y);
         e1_ff[2] <= NW'(req.b_z) - NW'(req.a_z);
         e2_ff[0] <= NW'(req.c_x) - NW'(req.a_x);
         e2_ff[1] <= NW'(req.c_y) - NW'(req.a_y);
         e2_ff[2] <= NW'(req.c_z) - NW'(req.a_z);
         idx_ff   <= req.tri_index;
      end
      if (cmd.mac) begin
         acc_ff <= acc_in;
         unique case (cmd.uop.dest)
            rtc_pkg::DST_H0:  wide_ff[0] <= acc_in[WW-1:0];
            rtc_pkg::DST_H1:  wide_ff[1] <= acc_in[WW-1:0];
            rtc_pkg::DST_H2:  wide_ff[2] <= acc_in[WW-1:0];
            rtc_pkg::DST_Q0:  wide_ff[3] <= acc_in[WW-1:0];
            rtc_pkg::DST_Q1:  wide_ff[4] <= acc_in[WW-1:0];
            rtc_pkg::DST_Q2:  wide_ff[5] <= acc_in[WW-1:0];
            rtc_pkg::DST_DET: det_ff <= acc_in;
            rtc_pkg::DST_U:   u_ff <= acc_in;
            rtc_pkg::DST_V:   v_ff <= acc_in;
            rtc_pkg::DST_T:   t_ff <= acc_in;
            default: ;
         endcase
      end
      if (cmd.norm) begin
         det_ff <= neg ? -det_ff : det_ff;
         u_ff   <= neg ? -u_ff : u_ff;
         v_ff   <= neg ? -v_ff : v_ff;
         t_ff   <= neg ? -t_ff : t_ff;
      end
      if (cmd.check) begin
         ok_ff   <= range_ok && !overflow;
         rem_ff  <= num0;
         dv_ff   <= dv0;
         quot_ff <= '0;
      end
      if (cmd.div_step) begin
         if (take) begin
            rem_ff <= rem_sub;
         end
         dv_ff   <= dv_ff >> 1;
         quot_ff <= {quot_ff[29:0], take};
      end
      if (cmd.commit && last_ff) begin
         rsp_ff.hit          <= have_new;
         rsp_ff.hit_distance <= have_new ? dist_new : '0;
         rsp_ff.hit_index    <= have_new ? idx_new : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= 1'b0;
         have_ff      <= 1'b0;
         best_dist_ff <= '0;
         best_idx_ff  <= '0;
      end else begin
         if (cmd.load) begin
            last_ff <= req.final_candidate;
         end
         if (cmd.commit) begin
            if (last_ff) begin
               have_ff      <= 1'b0;
               best_dist_ff <= '0;
               best_idx_ff  <= '0;
            end else begin
               have_ff      <= have_new;
               best_dist_ff <= dist_new;
               best_idx_ff  <= idx_new;
            end
         end
      end
   end

endmodule

### hw/rtl/ray_triangle_closest_hit_top.sv
// ray_triangle_closest_hit_top: one triangle at a time (an accept step, 36 shared
// multiply-accumulate steps, a sign fix, a check, 31 divide steps, a commit),
// set by the single multiplier and the bit-per-cycle divider; no new triangle is
// accepted before the previous one commits, and a final commit stalls only while an
// earlier result still waits on rsp_chan.ready
// reset (synchronous) restores the ray registers and clears the running hit
module ray_triangle_closest_hit_top #(
   parameter int FRAC_BITS  = 16,
   parameter int INDEX_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   rtc_req_if.sink    req_chan,
   rtc_rsp_if.source  rsp_chan,
   rtc_csr_if.sink    csr_chan
);

   rtc_pkg::ray_type    ray_ff;
   rtc_pkg::req_type    req_data;
   rtc_pkg::cmd_type    cmd;
   rtc_pkg::status_type status;
   rtc_pkg::rsp_type    rsp_data;

   // csr writes are taken every cycle; the host is to write only while idle, which the block does not enforce
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff.origin_x       <= '0;
         ray_ff.origin_y       <= '0;
         ray_ff.origin_z       <= '0;
         ray_ff.dir_x          <= '0;
         ray_ff.dir_y          <= '0;
         ray_ff.dir_z          <= 32'sd65536;
         ray_ff.distance_limit <= 31'h7FFF_FFFF;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            rtc_pkg::REG_ORIGIN_X: ray_ff.origin_x       <= csr_chan.data;
            rtc_pkg::REG_ORIGIN_Y: ray_ff.origin_y       <= csr_chan.data;
            rtc_pkg::REG_ORIGIN_Z: ray_ff.origin_z       <= csr_chan.data;
            rtc_pkg::REG_DIR_X:    ray_ff.dir_x          <= csr_chan.data;
            rtc_pkg::REG_DIR_Y:    ray_ff.dir_y          <= csr_chan.data;
            rtc_pkg::REG_DIR_Z:    ray_ff.dir_z          <= csr_chan.data;
            rtc_pkg::REG_LIMIT:    ray_ff.distance_limit <= csr_chan.data[30:0];
            default: ;
         endcase
      end
   end

   // request payload gathered for the datapath
   always_comb begin
      req_data.a_x             = req_chan.a_x;
      req_data.a_y             = req_chan.a_y;
      req_data.a_z             = req_chan.a_z;
      req_data.b_x             = req_chan.b_x;
      req_data.b_y             = req_chan.b_y;
      req_data.b_z             = req_chan.b_z;
      req_data.c_x             = req_chan.c_x;
      req_data.c_y             = req_chan.c_y;
      req_data.c_z             = req_chan.c_z;
      req_data.tri_index       = req_chan.tri_index;
      req_data.final_candidate = req_chan.final_candidate;
   end

   // sequencer: ready only between triangles; the result register lets a new
   // transaction in while the previous result still waits
   rtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // exact wide-integer test and divide, plus running closest hit
   rtc_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .req    (req_data),
      .ray    (ray_ff),
      .status (status),
      .rsp    (rsp_data)
   );

   assign rsp_chan.hit          = rsp_data.hit;
   assign rsp_chan.hit_distance = rsp_data.hit_distance;
   assign rsp_chan.hit_index    = rsp_data.hit_index;

endmodule
